### hdl/mrtm_pkg.sv
package mrtm_pkg;

  localparam int unsigned MAX_ENTRIES = 32;
  localparam int unsigned ADDR_WIDTH  = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned TYPE_W      = 2;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(32);
  localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_ENTRIES);

  localparam logic [DATA_W-1:0] WORD_STEP  = DATA_W'(4);
  localparam logic [63:0]       ADDR_ONES  = (64'h1 << ADDR_WIDTH) - 64'h1;
  localparam logic [DATA_W-1:0] ADDR_MASK  = ADDR_ONES[DATA_W-1:0] & 32'hFFFF_FFFC;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_UPDATE = 2'd2
  } req_type_e;

  typedef struct packed {
    logic             success;
    logic [IDX_W-1:0] entry_index;
    logic             boundary_write;
  } rsp_t;

  // one stored region: attribute, inclusive limit, base
  typedef struct packed {
    logic [DATA_W-1:0] attr;
    logic [DATA_W-1:0] limit;
    logic [DATA_W-1:0] base;
  } entry_t;

endpackage

### hdl/mrtm_cfg_if.sv
interface mrtm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mrtm_pkg::CNT_W-1:0]  entry_count;

  modport source (output valid, output entry_count, input ready);
  modport sink   (input valid, input entry_count, output ready);
endinterface

### hdl/mrtm_req_if.sv
interface mrtm_req_if;
  logic                         valid;
  logic                         ready;
  logic [mrtm_pkg::TYPE_W-1:0]  req_type;
  logic [mrtm_pkg::DATA_W-1:0]  region_base;
  logic [mrtm_pkg::DATA_W-1:0]  region_size;
  logic [mrtm_pkg::DATA_W-1:0]  region_attr;
  logic                         lock_request;

  modport source (output valid, output req_type, output region_base, output region_size,
                  output region_attr, output lock_request, input ready);
  modport sink   (input valid, input req_type, input region_base, input region_size,
                  input region_attr, input lock_request, output ready);
endinterface

### hdl/mrtm_rsp_if.sv
interface mrtm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [mrtm_pkg::IDX_W-1:0]  entry_index;
  logic                        boundary_write;

  modport source (output valid, output success, output entry_index, output boundary_write,
                  input ready);
  modport sink   (input valid, input success, input entry_index, input boundary_write,
                  output ready);
endinterface

### hdl/mpu_region_table_manager.sv
// MPU region table manager. Keeps up to 32 protection regions (base, inclusive
// limit, attribute) in a single-port-read region RAM, with used and lock marks in
// flops. One request word is taken at a time and answered with one response word.
// Add picks the highest free entry below entry_count from the used marks; remove
// and update walk the RAM one entry per cycle from entry 0 through the one read
// port of the region RAM. A new request is taken while a response still waits on
// a stalled output. The user must write entry_count through the config port only
// while idle; the block itself does not enforce it. 0 acts as 1 and values above
// 32 act as 32. No clearing pass is needed after reset.
module mpu_region_table_manager (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrtm_cfg_if.sink    cfg_i,
  mrtm_req_if.sink    req_i,
  mrtm_rsp_if.source  rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam int unsigned NE = mrtm_pkg::MAX_ENTRIES;
  localparam int unsigned IW = mrtm_pkg::IDX_W;
  localparam int unsigned CW = mrtm_pkg::CNT_W;
  localparam int unsigned DW = mrtm_pkg::DATA_W;

  state_e state_q, state_d;

  logic [CW-1:0] cnt_q;
  logic [CW-1:0] n_q, n_d;
  logic [mrtm_pkg::TYPE_W-1:0] type_q;
  logic [DW-1:0] key_q, size_q, lim_q, attr_q;
  logic          lock_req_q;

  logic [NE-1:0] used_q, used_d;
  logic [NE-1:0] lock_mk_q, lock_d;

  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;

  mrtm_pkg::rsp_t res_q, res_d;
  mrtm_pkg::rsp_t out_q;
  logic           out_vld_q;
  logic           out_load;

  mrtm_pkg::entry_t mem [NE];
  mrtm_pkg::entry_t rd_data_q;
  mrtm_pkg::entry_t wdata;
  logic             mem_we, rd_en;
  logic [IW-1:0]    waddr;

  logic          req_accept;
  logic [NE-1:0] free_mask;
  logic [IW-1:0] add_idx;
  logic          add_hit;
  logic [DW-1:0] stored_size;
  logic          match;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= mrtm_pkg::COUNT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      cnt_q <= cfg_i.entry_count;
    end
  end

  // clamp the programmed count to 1..MAX_ENTRIES
  always_comb begin
    priority if (cnt_q == '0) begin
      n_d = CW'(1);
    end else if (cnt_q > mrtm_pkg::COUNT_MAX) begin
      n_d = mrtm_pkg::COUNT_MAX;
    end else begin
      n_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      type_q     <= req_i.req_type;
      key_q      <= req_i.region_base & mrtm_pkg::ADDR_MASK;
      size_q     <= req_i.region_size;
      lim_q      <= (req_i.region_base + req_i.region_size - mrtm_pkg::WORD_STEP)
                    & mrtm_pkg::ADDR_MASK;
      attr_q     <= req_i.region_attr;
      lock_req_q <= req_i.lock_request;
      n_q        <= n_d;
    end
  end

  // highest free entry below the active count
  always_comb begin
    add_idx = '0;
    for (int i = 0; i < NE; i++) begin
      free_mask[i] = !used_q[i] && (CW'(i) < n_q);
      if (free_mask[i]) begin
        add_idx = IW'(i);
      end
    end
    add_hit = |free_mask;
  end

  assign stored_size = rd_data_q.limit - rd_data_q.base + mrtm_pkg::WORD_STEP;
  assign match = cmp_vld_q && used_q[cmp_idx_q] && (rd_data_q.base == key_q) &&
                 ((type_q != mrtm_pkg::REQ_REMOVE) || (stored_size == size_q));

  assign wdata = '{attr: attr_q, limit: lim_q, base: key_q};

  always_comb begin
    state_d   = state_q;
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    waddr     = '0;
    used_d    = used_q;
    lock_d    = lock_mk_q;
    res_d     = res_q;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_accept) begin
          state_d  = ST_SCAN;
          rd_idx_d = '0;
        end
      end
      ST_SCAN: begin
        unique case (type_q)
          mrtm_pkg::REQ_ADD: begin
            state_d = ST_DONE;
            if ((size_q != '0) && add_hit) begin
              mem_we          = 1'b1;
              waddr           = add_idx;
              used_d[add_idx] = 1'b1;
              if (lock_req_q) begin
                lock_d[add_idx] = 1'b1;
              end
              res_d = '{success: 1'b1, entry_index: add_idx, boundary_write: 1'b1};
            end else begin
              res_d = '0;
            end
          end
          mrtm_pkg::REQ_REMOVE, mrtm_pkg::REQ_UPDATE: begin
            priority if ((type_q == mrtm_pkg::REQ_REMOVE) && (size_q == '0)) begin
              res_d   = '0;
              state_d = ST_DONE;
            end else if (match) begin
              res_d   = '{success: 1'b1, entry_index: cmp_idx_q, boundary_write: 1'b0};
              state_d = ST_DONE;
              if (type_q == mrtm_pkg::REQ_REMOVE) begin
                used_d[cmp_idx_q] = 1'b0;
              end else begin
                mem_we = 1'b1;
                waddr  = cmp_idx_q;
              end
            end else if (cmp_vld_q && (rd_idx_q == n_q)) begin
              res_d   = '0;
              state_d = ST_DONE;
            end else if (rd_idx_q < n_q) begin
              rd_en     = 1'b1;
              rd_idx_d  = rd_idx_q + CW'(1);
              cmp_vld_d = 1'b1;
              cmp_idx_d = rd_idx_q[IW-1:0];
            end else begin
              state_d = state_q;
            end
          end
          default: begin
            res_d   = '0;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      lock_mk_q <= '0;
      cmp_vld_q <= 1'b0;
      rd_idx_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      lock_mk_q <= lock_d;
      cmp_vld_q <= cmp_vld_d;
      rd_idx_q  <= rd_idx_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // region RAM, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_idx_q[IW-1:0]];
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.success        = out_q.success;
  assign rsp_o.entry_index    = out_q.entry_index;
  assign rsp_o.boundary_write = out_q.boundary_write;

`ifndef SYNTHESIS
  a_bound_needs_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.boundary_write |-> out_q.success)
    else $error("boundary write without success");

  a_add_marks_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && (type_q == mrtm_pkg::REQ_ADD) && mem_we
    |=> used_q[$past(add_idx)])
    else $error("added entry not marked used");

  a_add_marks_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && (type_q == mrtm_pkg::REQ_ADD) && mem_we && lock_req_q
    |=> lock_mk_q[$past(add_idx)])
    else $error("locked add left lock mark clear");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && cmp_vld_q |-> (CW'(cmp_idx_q) < n_q))
    else $error("scan compared beyond active count");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_SCAN) && !rd_en)
    else $error("region RAM written outside scan");
`endif

endmodule

### dv/tb_mpu_region_table_manager.sv
`timescale 1ns / 100ps

module tb_mpu_region_table_manager;
  import mrtm_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED   = 2'd3;
  localparam int unsigned       IDLE_LIMIT   = 2000;
  localparam int unsigned       DRAIN_CYCLES = MAX_ENTRIES + 8;
  localparam int unsigned       PHASES       = 8;
  localparam int unsigned       PHASE_ITEMS  = 70;
  localparam rsp_t              RSP_FAIL     = '0;

  localparam logic [CNT_W-1:0] PHASE_COUNT [PHASES] =
    '{6'd32, 6'd0, 6'd63, 6'd1, 6'd8, 6'd40, 6'd2, 6'd20};

  typedef struct packed {
    logic [TYPE_W-1:0] typ;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] attr;
    logic              lock;
  } region_req_t;

  typedef struct packed {
    logic [TYPE_W-1:0] typ;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] attr;
    logic              lock;
    logic              typed;
    rsp_t              rsp;
  } dir_row_t;

  // typed rows carry their own answer; every row also updates the table model, which answers the rest
  localparam dir_row_t DIR_ROWS [21] = '{
    '{REQ_ADD,    32'h0000_1000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, RSP_FAIL},
    '{REQ_REMOVE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, RSP_FAIL},
    '{REQ_UNUSED, 32'h0000_1000, 32'h0000_0100, 32'hFFFF_FFFF, 1'b1, 1'b1, RSP_FAIL},
    '{REQ_UPDATE, 32'h0000_1000, 32'h0000_0100, 32'h0000_0001, 1'b0, 1'b1, RSP_FAIL},
    '{REQ_REMOVE, 32'h0000_1000, 32'h0000_0100, 32'h0000_0000, 1'b0, 1'b1, RSP_FAIL},
    '{REQ_ADD,    32'h0000_1000, 32'h0000_0100, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{1'b1, 5'd31, 1'b1}},
    '{REQ_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1,
      '{1'b1, 5'd30, 1'b1}},
    '{REQ_ADD,    32'h0000_0000, 32'h0000_0004, 32'hA5A5_A5A5, 1'b0, 1'b1,
      '{1'b1, 5'd29, 1'b1}},
    '{REQ_ADD,    32'hFFFF_FFF0, 32'h0000_0020, 32'h0000_FFFF, 1'b1, 1'b1,
      '{1'b1, 5'd28, 1'b1}},
    '{REQ_UPDATE, 32'h0000_1002, 32'h0000_0000, 32'h5A5A_5A5A, 1'b0, 1'b0, '0},
    '{REQ_REMOVE, 32'h0000_1000, 32'h0000_0100, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{REQ_UPDATE, 32'h0000_1000, 32'h0000_0100, 32'h1234_5678, 1'b1, 1'b0, '0},
    '{REQ_REMOVE, 32'h0000_1003, 32'h0000_0100, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{REQ_REMOVE, 32'h0000_1000, 32'h0000_0100, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{REQ_REMOVE, 32'hFFFF_FFFC, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, RSP_FAIL},
    '{REQ_REMOVE, 32'hFFFF_FFF0, 32'h0000_0020, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{REQ_ADD,    32'h0000_2000, 32'h0000_0040, 32'h0F0F_0F0F, 1'b0, 1'b0, '0},
    '{REQ_REMOVE, 32'h0000_0000, 32'h0000_0004, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{REQ_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{REQ_REMOVE, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1, RSP_FAIL},
    '{REQ_ADD,    32'h7FFF_FFFC, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  mrtm_cfg_if cfg_if ();
  mrtm_req_if req_if ();
  mrtm_rsp_if rsp_if ();

  mpu_region_table_manager u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // region table model
  logic [DATA_W-1:0] rgn_base  [MAX_ENTRIES] = '{default: '0};
  logic [DATA_W-1:0] rgn_limit [MAX_ENTRIES] = '{default: '0};
  logic [DATA_W-1:0] rgn_attr  [MAX_ENTRIES] = '{default: '0};
  bit                rgn_used  [MAX_ENTRIES] = '{default: 1'b0};
  bit                rgn_lock  [MAX_ENTRIES] = '{default: 1'b0};
  logic [CNT_W-1:0]  entry_count_q = COUNT_RESET;

  rsp_t        rsp_pending [$];
  rsp_t        want_rsp;
  int unsigned err_cnt       = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned quiet_cycles  = 0;

  function automatic int active_count();
    if (entry_count_q == '0) return 1;
    if (entry_count_q > COUNT_MAX) return MAX_ENTRIES;
    return int'(entry_count_q);
  endfunction

  function automatic logic [DATA_W-1:0] stored_size(int i);
    return rgn_limit[i] - rgn_base[i] + WORD_STEP;
  endfunction

  function automatic void store_region(int i, region_req_t r);
    rgn_base[i]  = r.base & ADDR_MASK;
    rgn_limit[i] = (r.base + r.size - WORD_STEP) & ADDR_MASK;
    rgn_attr[i]  = r.attr;
  endfunction

  function automatic rsp_t apply_region_req(region_req_t r);
    rsp_t              res = '0;
    int                n   = active_count();
    logic [DATA_W-1:0] key = r.base & ADDR_MASK;
    case (r.typ)
      REQ_ADD: begin
        if (r.size != '0) begin
          // highest free entry wins
          for (int i = n - 1; i >= 0; i--) begin
            if (!rgn_used[i]) begin
              rgn_used[i] = 1'b1;
              store_region(i, r);
              if (r.lock) rgn_lock[i] = 1'b1;
              res = '{success: 1'b1, entry_index: IDX_W'(i), boundary_write: 1'b1};
              break;
            end
          end
        end
      end
      REQ_REMOVE: begin
        if (r.size != '0) begin
          for (int i = 0; i < n; i++) begin
            if (rgn_used[i] && rgn_base[i] == key && stored_size(i) == r.size) begin
              rgn_base[i]  = '0;
              rgn_limit[i] = '0;
              rgn_attr[i]  = '0;
              rgn_used[i]  = 1'b0;
              res = '{success: 1'b1, entry_index: IDX_W'(i), boundary_write: 1'b0};
              break;
            end
          end
        end
      end
      REQ_UPDATE: begin
        for (int i = 0; i < n; i++) begin
          if (rgn_used[i] && rgn_base[i] == key) begin
            store_region(i, r);
            res = '{success: 1'b1, entry_index: IDX_W'(i), boundary_write: 1'b0};
            break;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // removes and updates mostly aim at a live region, so they get past the search
  function automatic region_req_t random_req();
    region_req_t r;
    int          n     = active_count();
    int          start = $urandom_range(0, n - 1);
    int          hit   = -1;
    int unsigned pick  = $urandom_range(0, 99);
    for (int k = 0; k < n; k++) begin
      if (hit < 0 && rgn_used[(start + k) % n]) hit = (start + k) % n;
    end
    r.typ  = REQ_UNUSED;
    r.base = $urandom;
    case ($urandom_range(0, 9))
      0:       r.size = '0;
      1:       r.size = $urandom;
      default: r.size = DATA_W'($urandom_range(1, 4096)) << 2;
    endcase
    r.attr = $urandom;
    r.lock = $urandom_range(0, 1);
    if (pick < 38) begin
      r.typ = REQ_ADD;
      if (hit >= 0 && $urandom_range(0, 3) == 0) r.base = rgn_base[hit];
    end else if (pick < 72) begin
      r.typ = REQ_REMOVE;
      if (hit >= 0 && $urandom_range(0, 4) != 0) begin
        r.base = rgn_base[hit] | DATA_W'($urandom_range(0, 3));
        r.size = stored_size(hit);
      end
    end else if (pick < 92) begin
      r.typ = REQ_UPDATE;
      if (hit >= 0 && $urandom_range(0, 4) != 0)
        r.base = rgn_base[hit] | DATA_W'($urandom_range(0, 3));
    end
    return r;
  endfunction

  task automatic send_req(region_req_t r, logic typed, rsp_t typed_rsp);
    rsp_t predicted;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= r.typ;
    req_if.region_base  <= r.base;
    req_if.region_size  <= r.size;
    req_if.region_attr  <= r.attr;
    req_if.lock_request <= r.lock;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = apply_region_req(r);
    rsp_pending.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic write_entry_count(logic [CNT_W-1:0] value);
    req_if.valid <= 1'b0;
    while (rsp_pending.size() != 0) @(posedge clk_i);
    // remove and update may still be walking the table
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_if.valid       <= 1'b1;
    cfg_if.entry_count <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid  <= 1'b0;
    entry_count_q = value;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_pending.size() == 0) begin
          $error("response word with nothing outstanding");
          err_cnt++;
        end else begin
          want_rsp = rsp_pending.pop_front();
          if (rsp_if.success !== want_rsp.success) begin
            $error("success: expected %0d, got %0d", want_rsp.success, rsp_if.success);
            err_cnt++;
          end
          if (rsp_if.entry_index !== want_rsp.entry_index) begin
            $error("entry_index: expected %0d, got %0d", want_rsp.entry_index,
                   rsp_if.entry_index);
            err_cnt++;
          end
          if (rsp_if.boundary_write !== want_rsp.boundary_write) begin
            $error("boundary_write: expected %0d, got %0d", want_rsp.boundary_write,
                   rsp_if.boundary_write);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("tb_mpu_region_table_manager: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    region_req_t      dreq;
    logic [CNT_W-1:0] count_val;
    rst_ni              = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.entry_count  = '0;
    req_if.valid        = 1'b0;
    req_if.req_type     = '0;
    req_if.region_base  = '0;
    req_if.region_size  = '0;
    req_if.region_attr  = '0;
    req_if.lock_request = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows run at the reset entry count
    foreach (DIR_ROWS[k]) begin
      dreq = '{DIR_ROWS[k].typ, DIR_ROWS[k].base, DIR_ROWS[k].size, DIR_ROWS[k].attr,
               DIR_ROWS[k].lock};
      send_req(dreq, DIR_ROWS[k].typed, DIR_ROWS[k].rsp);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      count_val = (p == PHASES - 1) ? CNT_W'($urandom_range(1, 32)) : PHASE_COUNT[p];
      write_entry_count(count_val);
      repeat (PHASE_ITEMS) send_req(random_req(), 1'b0, '0);
    end

    req_if.valid <= 1'b0;
    while (rsp_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_mpu_region_table_manager: clean");
    end else begin
      $display("tb_mpu_region_table_manager: errors");
    end
    $finish;
  end

endmodule
